// ----- rtl/knps_pkg.sv -----
`default_nettype none

package knps_pkg;

    localparam int MAX_KEEP     = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int KEEP_W       = 5;
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int DIST_W       = SQ_W + 1;
    localparam int K_W          = $clog2(MAX_KEEP + 1);
    localparam int IDX_W        = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = (COORD_WIDTH > KEEP_W) ? COORD_WIDTH : KEEP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 2'd0,
        CFG_ORIGIN_Y   = 2'd1,
        CFG_KEEP_COUNT = 2'd2
    } t_cfg_reg;

    // one ranked candidate
    typedef struct packed {
        logic [DIST_W-1:0]             dist_sq;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_entry;

    // one result waiting in the drain row
    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic                   last;
    } t_out;

    // item leaving the distance pipe
    typedef struct packed {
        t_entry         entry;
        logic           last;
        logic [K_W-1:0] k;
    } t_stage;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic           ins_en;
        logic           dump;
        logic           shift;
        logic [K_W-1:0] k;
    } t_cell_ctl;

    // strict rank order: distance, then smaller x, then smaller y
    function automatic logic ranks_before(t_entry a, t_entry b);
        logic [COORD_WIDTH-1:0]            sign_bit;
        logic [DIST_W+2*COORD_WIDTH-1:0]   ka;
        logic [DIST_W+2*COORD_WIDTH-1:0]   kb;
        sign_bit = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        ka = {a.dist_sq, a.x ^ sign_bit, a.y ^ sign_bit};
        kb = {b.dist_sq, b.x ^ sign_bit, b.y ^ sign_bit};
        return ka < kb;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/knps_dist.sv -----
`default_nettype none

module knps_dist (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_adv,
    input  wire logic                                  i_valid,
    input  wire logic signed [knps_pkg::COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [knps_pkg::COORD_WIDTH-1:0] i_point_y,
    input  wire logic                                  i_last,
    input  wire logic signed [knps_pkg::COORD_WIDTH-1:0] i_origin_x,
    input  wire logic signed [knps_pkg::COORD_WIDTH-1:0] i_origin_y,
    input  wire logic [knps_pkg::K_W-1:0]              i_k,
    output logic                                       o_valid,
    output knps_pkg::t_stage                           o_stage
);

    localparam int CW = knps_pkg::COORD_WIDTH;

    // stage 1: differences
    logic                                  r_s1_valid;
    logic signed [knps_pkg::DIFF_W-1:0]    r_s1_dx;
    logic signed [knps_pkg::DIFF_W-1:0]    r_s1_dy;
    logic signed [CW-1:0]                  r_s1_x;
    logic signed [CW-1:0]                  r_s1_y;
    logic                                  r_s1_last;
    logic [knps_pkg::K_W-1:0]              r_s1_k;
    // stage 2: squares
    logic                                  r_s2_valid;
    logic [knps_pkg::SQ_W-1:0]             r_s2_sx;
    logic [knps_pkg::SQ_W-1:0]             r_s2_sy;
    logic signed [CW-1:0]                  r_s2_x;
    logic signed [CW-1:0]                  r_s2_y;
    logic                                  r_s2_last;
    logic [knps_pkg::K_W-1:0]              r_s2_k;
    // stage 3: distance
    logic                                  r_s3_valid;
    knps_pkg::t_stage                      r_s3;

    logic signed [knps_pkg::DIFF_W-1:0]    n_dx;
    logic signed [knps_pkg::DIFF_W-1:0]    n_dy;
    logic signed [knps_pkg::SQ_W-1:0]      n_sqx;
    logic signed [knps_pkg::SQ_W-1:0]      n_sqy;
    logic [knps_pkg::DIST_W-1:0]           n_dist;

    assign n_dx   = $signed({i_point_x[CW-1], i_point_x}) - $signed({i_origin_x[CW-1], i_origin_x});
    assign n_dy   = $signed({i_point_y[CW-1], i_point_y}) - $signed({i_origin_y[CW-1], i_origin_y});
    assign n_sqx  = r_s1_dx * r_s1_dx;
    assign n_sqy  = r_s1_dy * r_s1_dy;
    assign n_dist = {1'b0, r_s2_sx} + {1'b0, r_s2_sy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_dx            <= n_dx;
            r_s1_dy            <= n_dy;
            r_s1_x             <= i_point_x;
            r_s1_y             <= i_point_y;
            r_s1_last          <= i_last;
            r_s1_k             <= i_k;
            r_s2_sx            <= n_sqx;
            r_s2_sy            <= n_sqy;
            r_s2_x             <= r_s1_x;
            r_s2_y             <= r_s1_y;
            r_s2_last          <= r_s1_last;
            r_s2_k             <= r_s1_k;
            r_s3.entry.dist_sq <= n_dist;
            r_s3.entry.x       <= r_s2_x;
            r_s3.entry.y       <= r_s2_y;
            r_s3.last          <= r_s2_last;
            r_s3.k             <= r_s2_k;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_stage = r_s3;

endmodule

`default_nettype wire

// ----- rtl/knps_cell.sv -----
`default_nettype none

module knps_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire knps_pkg::t_cell_ctl        i_ctl,
    input  wire logic [knps_pkg::IDX_W-1:0] i_index,
    input  wire knps_pkg::t_entry           i_new,
    input  wire knps_pkg::t_entry           i_prev_entry,
    input  wire logic                       i_prev_valid,
    input  wire logic                       i_prev_ins,
    output logic                            o_ins,
    output knps_pkg::t_entry                o_entry,
    output logic                            o_valid,
    output logic                            o_n_valid,
    input  wire logic                       i_next_n_valid,
    input  wire knps_pkg::t_out             i_next_out,
    input  wire logic                       i_next_ov,
    output knps_pkg::t_out                  o_out,
    output logic                            o_ov
);

    knps_pkg::t_entry r_entry;
    knps_pkg::t_entry n_entry;
    logic             r_valid;
    logic             n_valid;
    knps_pkg::t_out   r_out;
    knps_pkg::t_out   n_out;
    logic             r_ov;
    logic             n_ov;

    always_comb begin
        // new item goes here or earlier
        o_ins   = !r_valid || knps_pkg::ranks_before(i_new, r_entry);
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.ins_en) begin
            if (i_prev_ins) begin
                n_entry = i_prev_entry;
                n_valid = i_prev_valid;
            end else if (o_ins) begin
                n_entry = i_new;
                n_valid = 1'b1;
            end
            // positions at or beyond k hold nothing
            if (knps_pkg::K_W'(i_index) >= i_ctl.k) begin
                n_valid = 1'b0;
            end
        end

        n_out = r_out;
        n_ov  = r_ov;
        if (i_ctl.dump) begin
            n_out.x    = n_entry.x;
            n_out.y    = n_entry.y;
            n_out.last = n_valid && !i_next_n_valid;
            n_ov       = n_valid;
        end else if (i_ctl.shift) begin
            n_out = i_next_out;
            n_ov  = i_next_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_valid <= n_valid && !i_ctl.dump;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_out   <= n_out;
    end

    assign o_entry   = r_entry;
    assign o_valid   = r_valid;
    assign o_n_valid = n_valid;
    assign o_out     = r_out;
    assign o_ov      = r_ov;

endmodule

`default_nettype wire

// ----- rtl/k_nearest_points_select.sv -----
// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_stall    i_point_x, i_point_y, i_last_point
// out       source     o_out_valid / i_out_stall  o_near_x, o_near_y, o_last_result
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one point is taken every cycle unless the input stalls; a point passes the difference, square and distance registers
// before it reaches the cell row; a run of n results starts the cycle after the final point is ranked, head first
// the input stalls only when a final point reaches the cells while the previous run drains
// reset sets origin 0,0 and keep count 1 and empties the cells and the drain row
// output stall holds the drain row; the cells keep ranking until a new run must load
`default_nettype none

module k_nearest_points_select (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_stall,
    input  wire logic signed [knps_pkg::COORD_WIDTH-1:0]  i_point_x,
    input  wire logic signed [knps_pkg::COORD_WIDTH-1:0]  i_point_y,
    input  wire logic                                     i_last_point,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_stall,
    output logic signed [knps_pkg::COORD_WIDTH-1:0]       o_near_x,
    output logic signed [knps_pkg::COORD_WIDTH-1:0]       o_near_y,
    output logic                                          o_last_result,
    input  wire logic                                     i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  wire logic [knps_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  wire logic [knps_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int MK = knps_pkg::MAX_KEEP;
    localparam int CW = knps_pkg::COORD_WIDTH;

    // configuration registers
    logic signed [CW-1:0]            r_origin_x;
    logic signed [CW-1:0]            r_origin_y;
    logic [knps_pkg::KEEP_W-1:0]     r_keep_count;
    logic [knps_pkg::K_W-1:0]        w_k;

    // distance pipe output
    logic                            w_s3_valid;
    knps_pkg::t_stage                w_s3;

    // handshake control
    logic                            w_out_free;
    logic                            w_adv;
    knps_pkg::t_cell_ctl             w_ctl;

    // chains between cells: index g+1 carries cell g forward, index g carries cell g back
    logic [MK:0]                     w_ins_ch;
    logic [MK:0]                     w_val_ch;
    knps_pkg::t_entry                w_ent_ch [MK+1];
    logic [MK:0]                     w_nval_ch;
    logic [MK:0]                     w_ov_ch;
    knps_pkg::t_out                  w_out_ch [MK+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_keep_count <= knps_pkg::KEEP_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                knps_pkg::CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data[CW-1:0];
                knps_pkg::CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_data[CW-1:0];
                knps_pkg::CFG_KEEP_COUNT: r_keep_count <= i_cfg_data[knps_pkg::KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // keep count saturates at the row length; it travels with each point
    assign w_k = (int'(r_keep_count) > MK) ? knps_pkg::K_W'(MK)
                                           : knps_pkg::K_W'(r_keep_count);

    // drain row can take a new run once its head is empty or the final result leaves now
    assign w_out_free = !w_ov_ch[0] || (w_out_ch[0].last && !i_out_stall);
    assign w_adv      = !(w_s3_valid && w_s3.last && !w_out_free);
    assign o_in_stall = !w_adv;

    assign w_ctl.ins_en = w_s3_valid && w_adv;
    assign w_ctl.dump   = w_s3_valid && w_adv && w_s3.last;
    assign w_ctl.shift  = w_ov_ch[0] && !i_out_stall;
    assign w_ctl.k      = w_s3.k;

    knps_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (i_in_valid),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_last     (i_last_point),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .i_k        (w_k),
        .o_valid    (w_s3_valid),
        .o_stage    (w_s3)
    );

    // ends of the chains
    assign w_ins_ch[0]   = 1'b0;
    assign w_val_ch[0]   = 1'b0;
    assign w_ent_ch[0]   = '0;
    assign w_nval_ch[MK] = 1'b0;
    assign w_ov_ch[MK]   = 1'b0;
    assign w_out_ch[MK]  = '0;

    for (genvar g = 0; g < MK; g++) begin : g_cell
        knps_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_index        (knps_pkg::IDX_W'(g)),
            .i_new          (w_s3.entry),
            .i_prev_entry   (w_ent_ch[g]),
            .i_prev_valid   (w_val_ch[g]),
            .i_prev_ins     (w_ins_ch[g]),
            .o_ins          (w_ins_ch[g+1]),
            .o_entry        (w_ent_ch[g+1]),
            .o_valid        (w_val_ch[g+1]),
            .o_n_valid      (w_nval_ch[g]),
            .i_next_n_valid (w_nval_ch[g+1]),
            .i_next_out     (w_out_ch[g+1]),
            .i_next_ov      (w_ov_ch[g+1]),
            .o_out          (w_out_ch[g]),
            .o_ov           (w_ov_ch[g])
        );
    end

    // head of the drain row drives the result port
    assign o_out_valid   = w_ov_ch[0];
    assign o_near_x      = w_out_ch[0].x;
    assign o_near_y      = w_out_ch[0].y;
    assign o_last_result = w_out_ch[0].last;

`ifndef ASSERT_OFF
    // ranked entries always fill the row from the nearest end
    a_sort_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_val_ch[MK:1] & (w_val_ch[MK:1] + MK'(1))) == '0)
        else $error("ranked entries not contiguous");

    // waiting results always fill the drain row from its head
    a_out_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ov_ch[MK-1:0] & (w_ov_ch[MK-1:0] + MK'(1))) == '0)
        else $error("drain row not contiguous");

    // a run hand-off empties the cells, apart from a point ranked right after
    a_dump_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.dump |=> ($countones(w_val_ch[MK:1]) <= 1))
        else $error("cells not emptied after run hand-off");

    // the final result of a run has nothing behind it
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |-> !w_ov_ch[1])
        else $error("result queued behind final result");

    // a run does not break off before its final result
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_result && !i_out_stall) |=> o_out_valid)
        else $error("run ended without final result");
`endif

endmodule

`default_nettype wire
